// ===== rtl/per_frame_mean_variance_norm_assert.svh =====
// assertion macros for the per-frame normalizer module
// expects signals named clk and rst (synchronous, active high) in the including module
`ifndef PER_FRAME_MEAN_VARIANCE_NORM_ASSERT_SVH
`define PER_FRAME_MEAN_VARIANCE_NORM_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define MVN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("normalizer check failed");

// condition must hold in the cycle after the trigger
`define MVN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("normalizer check failed");

`endif

// ===== rtl/mvn_pkg.sv =====
// types and constants of the per-frame mean/variance normalizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mvn_pkg;

  localparam int MAX_DIM      = 64;
  localparam int SAMPLE_WIDTH = 16;

  localparam int POS_W  = $clog2(MAX_DIM);           // element index
  localparam int CNT_W  = $clog2(MAX_DIM + 1);       // element count, holds MAX_DIM
  localparam int SUM_W  = SAMPLE_WIDTH + POS_W;      // running sum of samples
  localparam int A_W    = SAMPLE_WIDTH + POS_W;      // |n*x - s|
  localparam int E_W    = A_W + 2;                   // signed scaled deviation
  localparam int SQ_W   = 2 * A_W + POS_W;           // sum of squares, n*a^2
  localparam int FRAC_SHIFT = 18;                    // extra quotient bits for the sqrt
  localparam int NUM_W  = SQ_W + FRAC_SHIFT;         // dividend width
  localparam int Q_W    = POS_W + FRAC_SHIFT + 1;    // quotient bits kept
  localparam int RAD_W  = Q_W + (Q_W % 2);           // radicand, even width
  localparam int ROOT_W = RAD_W / 2;

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [Q_W-1:0] MAG_LIMIT = Q_W'(2 ** (SAMPLE_WIDTH - 1));

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } sample_word_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic [POS_W-1:0]               position;
    logic                           end_of_frame;
  } result_word_t;

endpackage

// ===== rtl/per_frame_mean_variance_norm.sv =====
// Per-frame mean/variance normalizer. Samples (signed Q7.8) are taken one per cycle into a
// 64-entry frame buffer while the running sum builds; the word marked last closes the frame
// and samples beyond 64 are dropped. The block then stops taking samples until the whole frame
// has been emitted. With norm_variance set, a first pass squares every scaled deviation with
// the bit-serial multiplier; then each element is emitted after its square, times n, a restoring
// division and a square root, or as zero when the frame has no spread. Mean-only frames skip
// the first pass and use the serial divider alone. The configuration bit may only change
// between frames. Depends on mvn_pkg, mvn_mul, mvn_div, mvn_sqrt and the assertion
// macro header.
`timescale 1ns / 1ps
`include "per_frame_mean_variance_norm_assert.svh"

module per_frame_mean_variance_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  mvn_pkg::sample_word_t sample_word,
  output logic                  result_valid,
  input  logic                  result_stall,
  output mvn_pkg::result_word_t result_word
);
  import mvn_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,   // taking samples
    S_RD1,    // buffer read latency, square pass
    S_SQ1,    // start squaring the deviation
    S_SQ1W,   // accumulate square
    S_RD2,    // buffer read latency, emit pass
    S_EV,     // pick the per-element path
    S_SQ2W,   // a^2 running
    S_NMW,    // n * a^2 running
    S_DIVW,   // division running
    S_SQW,    // square root running
    S_FIN     // hand the word to the output register
  } state_t;

  state_t state;

  // configuration
  logic norm_variance;

  // frame state
  logic signed [SAMPLE_WIDTH-1:0] mem [0:MAX_DIM-1];
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        n;
  logic [POS_W-1:0]        k;
  logic [SQ_W-1:0]         sumsq;
  logic                    neg;
  logic [Q_W-1:0]          mag;

  // datapath around the shared serial units
  logic signed [E_W-1:0] e;
  logic [E_W-1:0]        e_abs;
  logic [A_W-1:0]        a_abs;
  logic                  last_k;
  logic                  sample_take;
  logic                  out_load;
  logic [CNT_W-1:0]      count_next;
  logic signed [SAMPLE_WIDTH-1:0] val;

  logic             mul_start, mul_done;
  logic [SQ_W-1:0]  mul_mcand, mul_prod;
  logic [A_W-1:0]   mul_mplier;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, mean_num;
  logic [SQ_W-1:0]  div_den;
  logic [Q_W-1:0]   div_quot;
  logic             sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [ROOT_W:0]  root_inc;

  assign sample_stall = (state != S_LOAD);
  assign sample_take  = sample_valid && !sample_stall;
  assign out_load     = (state == S_FIN) && (!result_valid || !result_stall);
  assign last_k       = ({1'b0, k} == n - 1'b1);
  assign count_next   = (count < CNT_W'(MAX_DIM)) ? count + 1'b1 : count;

  // scaled deviation n*x - s for the element being read
  assign e     = E_W'($signed({1'b0, n})) * E_W'(rd_data) - E_W'(sum);
  assign e_abs = e[E_W-1] ? -e : e;
  assign a_abs = e_abs[A_W-1:0];

  // mean only: round(a / n) as floor((2a + n) / 2n)
  assign mean_num = NUM_W'({a_abs, 1'b0}) + NUM_W'(n);

  assign mul_start  = (state == S_SQ1)
                   || (state == S_EV && norm_variance && sumsq != '0)
                   || (state == S_SQ2W && mul_done);
  assign mul_mcand  = (state == S_SQ2W) ? mul_prod : SQ_W'(a_abs);
  assign mul_mplier = (state == S_SQ2W) ? A_W'(n) : a_abs;

  assign div_start = (state == S_EV && !norm_variance) || (state == S_NMW && mul_done);
  assign div_num   = (state == S_NMW) ? {mul_prod, {FRAC_SHIFT{1'b0}}} : mean_num;
  assign div_den   = (state == S_NMW) ? sumsq : SQ_W'({n, 1'b0});

  assign sqrt_start = (state == S_DIVW) && div_done && norm_variance;
  assign root_inc   = {1'b0, sqrt_root} + 1'b1;

  mvn_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  mvn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  mvn_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (RAD_W'(div_quot)),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // saturate sign and magnitude to the sample range
  always_comb begin
    if (neg) begin
      val = (mag >= MAG_LIMIT) ? SMIN : -SAMPLE_WIDTH'(mag);
    end else begin
      val = (mag >= MAG_LIMIT) ? SMAX : SAMPLE_WIDTH'(mag);
    end
  end

  // frame buffer: written while loading, read in the cycle after the index moves
  always_ff @(posedge clk) begin
    if (sample_take && count < CNT_W'(MAX_DIM)) begin
      mem[count[POS_W-1:0]] <= sample_word.sample;
    end
    rd_data <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_variance <= 1'b0;
    end else if (cfg_we) begin
      norm_variance <= cfg_data;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      sum          <= '0;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      if (!result_stall) result_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (sample_take) begin
            if (count < CNT_W'(MAX_DIM)) begin
              sum <= sum + SUM_W'(sample_word.sample);
            end
            count <= count_next;
            if (sample_word.last) begin
              n     <= count_next;
              k     <= '0;
              sumsq <= '0;
              state <= norm_variance ? S_RD1 : S_RD2;
            end
          end
        end
        S_RD1: state <= S_SQ1;
        S_SQ1: state <= S_SQ1W;
        S_SQ1W: begin
          if (mul_done) begin
            sumsq <= sumsq + mul_prod;
            if (last_k) begin
              k     <= '0;
              state <= S_RD2;
            end else begin
              k     <= k + 1'b1;
              state <= S_RD1;
            end
          end
        end
        S_RD2: state <= S_EV;
        S_EV: begin
          neg <= e[E_W-1];
          if (!norm_variance) begin
            state <= S_DIVW;
          end else if (sumsq == '0) begin
            // zero spread
            mag   <= '0;
            state <= S_FIN;
          end else begin
            state <= S_SQ2W;
          end
        end
        S_SQ2W: if (mul_done) state <= S_NMW;
        S_NMW:  if (mul_done) state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            if (norm_variance) begin
              state <= S_SQW;
            end else begin
              mag   <= div_quot;
              state <= S_FIN;
            end
          end
        end
        S_SQW: begin
          if (sqrt_done) begin
            // nearest integer, ties upward
            mag   <= Q_W'(root_inc >> 1);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            result_valid             <= 1'b1;
            result_word.value        <= val;
            result_word.position     <= k;
            result_word.end_of_frame <= last_k;
            if (last_k) begin
              count <= '0;
              sum   <= '0;
              k     <= '0;
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_RD2;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // emitting the last word of a frame reopens the buffer empty
  `MVN_ASSERT_NEXT(a_frame_close, out_load && last_k, state == S_LOAD && count == '0)
  // the divider only finishes while the sequencer waits on it
  `MVN_ASSERT_NOW(a_div_owner, div_done, state == S_DIVW)
  // multiplier results arrive only in the states that consume them
  `MVN_ASSERT_NOW(a_mul_owner, mul_done,
                  state == S_SQ1W || state == S_SQ2W || state == S_NMW)
  // a loaded word leaves the output register valid
  `MVN_ASSERT_NEXT(a_out_load, out_load, result_valid)

endmodule

// ===== rtl/mvn_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on mvn_pkg; product is kept to SQ_W bits (callers never exceed it)
`timescale 1ns / 1ps

module mvn_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [mvn_pkg::SQ_W-1:0] mcand,
  input  logic [mvn_pkg::A_W-1:0]  mplier,
  output logic                    done,
  output logic [mvn_pkg::SQ_W-1:0] prod
);
  import mvn_pkg::*;

  localparam int CW = $clog2(A_W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SQ_W-1:0] m;
  logic [A_W-1:0]  b;
  logic [SQ_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(A_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m   <= mcand;
      b   <= mplier;
      acc <= '0;
    end else if (busy) begin
      if (b[0]) acc <= acc + m;
      m <= m << 1;
      b <= b >> 1;
    end
  end

  assign prod = acc;

endmodule

// ===== rtl/mvn_div.sv =====
// restoring divider, one quotient bit per cycle over the whole dividend
// depends on mvn_pkg; keeps the low Q_W quotient bits (upper bits are zero by range)
`timescale 1ns / 1ps

module mvn_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [mvn_pkg::NUM_W-1:0] num,
  input  logic [mvn_pkg::SQ_W-1:0]  den,
  output logic                     done,
  output logic [mvn_pkg::Q_W-1:0]   quot
);
  import mvn_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [NUM_W-1:0] nsr;
  logic [SQ_W-1:0]  den_r;
  logic [SQ_W-1:0]  rem;
  logic [SQ_W:0]    rem_sh;
  logic [SQ_W:0]    diff;
  logic             ge;

  assign rem_sh = {rem, nsr[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsr   <= num;
      den_r <= den;
      rem   <= '0;
      quot  <= '0;
    end else if (busy) begin
      nsr  <= nsr << 1;
      rem  <= ge ? diff[SQ_W-1:0] : rem_sh[SQ_W-1:0];
      quot <= {quot[Q_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/mvn_sqrt.sv =====
// digit-by-digit integer square root, one result bit (two radicand bits) per cycle
// depends on mvn_pkg; gives floor(sqrt(rad))
`timescale 1ns / 1ps

module mvn_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mvn_pkg::RAD_W-1:0]  rad,
  output logic                      done,
  output logic [mvn_pkg::ROOT_W-1:0] root
);
  import mvn_pkg::*;

  localparam int CW  = $clog2(ROOT_W);
  localparam int RW  = ROOT_W + 2;   // partial remainder
  localparam int RSW = RW + 2;       // shifted remainder and trial

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [RAD_W-1:0] rsr;
  logic [RW-1:0]    rem;
  logic [RSW-1:0]   rem_sh;
  logic [RSW-1:0]   trial;
  logic [RSW-1:0]   diff;
  logic             ge;

  assign rem_sh = {rem, rsr[RAD_W-1 -: 2]};
  assign trial  = RSW'({root, 2'b01});
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rsr  <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rsr  <= rsr << 2;
      rem  <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule
